// File: design/fsa_pkg.sv
package fsa_pkg;

  typedef enum logic [1:0] {
    KIND_SETUP  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ADD    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CAT_OOR = 2'd1,
    ST_BAD_IDX = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

  // front-end classified operation
  typedef struct packed {
    logic        setup;
    logic        sample;
    logic        add;
    logic        idx_ok;
    logic        cat_ok;
    logic        set_cat;
    logic [5:0]  feat;
    logic [31:0] nval;
    logic [15:0] cval;
    logic [15:0] added;
  } op_t;

endpackage

// File: design/fsa_front.sv
module fsa_front import fsa_pkg::*; #(
  parameter int NUM_FEATURES   = 64,
  parameter int NUM_CATEGORIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [5:0]  feature_index,
  input  logic        set_categorical,
  input  logic [31:0] numeric_value,
  input  logic [15:0] category_value,
  input  logic [15:0] examples_added,
  output logic        op_valid,
  input  logic        op_ready,
  output op_t         op
);

  // two-entry queue between front and back
  op_t        q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  op_t        cls;

  always_comb begin
    cls         = '0;
    cls.setup   = (kind == KIND_SETUP);
    cls.sample  = (kind == KIND_SAMPLE);
    cls.add     = (kind == KIND_ADD);
    cls.idx_ok  = ({26'd0, feature_index} < NUM_FEATURES);
    cls.cat_ok  = ({16'd0, category_value} < NUM_CATEGORIES);
    cls.set_cat = set_categorical;
    cls.feat    = feature_index;
    cls.nval    = numeric_value;
    cls.cval    = category_value;
    cls.added   = examples_added;
  end

  assign in_ready = (cnt != 2'd2);
  assign op_valid = (cnt != 2'd0);
  assign op       = q[rp];

  wire push = in_valid && in_ready;
  wire pop  = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cls;
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> op_valid)
    else $error("pushed entry lost");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd2) |-> !in_ready)
    else $error("accept while full");

endmodule

// File: design/fsa_back.sv
module fsa_back import fsa_pkg::*; #(
  parameter int NUM_CATEGORIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_ready,
  input  op_t         op,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] present_count,
  output logic [31:0] lowest_value,
  output logic [31:0] highest_value,
  output logic [63:0] value_sum,
  output logic [62:0] square_sum,
  output logic [31:0] bin_count,
  output logic [47:0] example_total
);

  localparam int CW    = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int HW    = 6 + CW;
  localparam int HD    = 64 << CW;

  // per-feature stores and histogram in RAM, all cleared by one sweep after reset
  logic        type_m  [64];
  logic [31:0] mark_m  [64];
  logic [31:0] cnt_m   [64];
  logic [31:0] min_m   [64];
  logic [31:0] max_m   [64];
  logic [63:0] sum_m   [64];
  logic [62:0] sq_m    [64];
  logic [47:0] total;
  logic [31:0] hist [HD];

  logic        clr_busy;
  logic [HW:0] clr_addr;

  // stage 1: op held with its registered store reads and square product
  logic        s1_v;
  op_t         s1;
  logic [31:0] s1_hrd;
  logic [63:0] s1_sqp;
  logic        s1_type;
  logic [31:0] s1_mark;
  logic [31:0] s1_cnt;
  logic [31:0] s1_min;
  logic [31:0] s1_max;
  logic [63:0] s1_sum;
  logic [62:0] s1_sq;

  logic out_hold;
  assign out_hold = out_valid && !out_ready;
  wire s1_go = s1_v && !out_hold;
  assign op_ready = !clr_busy && (!s1_v || s1_go);
  wire take = op_valid && op_ready;

  logic [HW-1:0] raddr;
  assign raddr = {op.feat, op.cval[CW-1:0]};

  logic [31:0] mag;
  assign mag = op.nval[31] ? (~op.nval + 32'd1) : op.nval;

  // stage 1 compute
  logic [5:0]  f;
  logic        is_cat, miss_n, miss_c, do_num, do_cat, do_bin;
  logic [31:0] cnt_inc, hinc, min_n, max_n, mark_new;
  logic [63:0] sum_n;
  logic [62:0] sq_n, sqv;
  logic [64:0] sum_w;
  logic [63:0] sq_w;
  logic [HW-1:0] ha;
  logic [48:0] tot_w;
  logic        wr_cfg, wr_cnt, wr_num, wr_bin, same_f;

  always_comb begin
    f       = s1.feat;
    is_cat  = s1_type;
    miss_n  = (s1.nval == s1_mark);
    miss_c  = ({16'd0, s1.cval} == s1_mark);
    do_num  = s1.sample && s1.idx_ok && !is_cat && !miss_n;
    do_cat  = s1.sample && s1.idx_ok && is_cat;
    do_bin  = do_cat && s1.cat_ok;
    cnt_inc = (s1_cnt == 32'hFFFF_FFFF) ? s1_cnt : s1_cnt + 32'd1;
    ha      = {f, s1.cval[CW-1:0]};
    hinc    = (s1_hrd == 32'hFFFF_FFFF) ? s1_hrd : s1_hrd + 32'd1;
    if (cnt_inc == 32'd1) begin
      min_n = s1.nval;
      max_n = s1.nval;
    end else begin
      min_n = ($signed(s1.nval) < $signed(s1_min)) ? s1.nval : s1_min;
      max_n = ($signed(s1.nval) > $signed(s1_max)) ? s1.nval : s1_max;
    end
    sum_w = {s1_sum[63], s1_sum} + {{33{s1.nval[31]}}, s1.nval};
    if (sum_w[64] != sum_w[63])
      sum_n = sum_w[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    else
      sum_n = sum_w[63:0];
    sqv  = {15'd0, s1_sqp[63:16]};
    sq_w = {1'b0, s1_sq} + {1'b0, sqv};
    sq_n = sq_w[63] ? MAX63 : sq_w[62:0];
    tot_w = {1'b0, total} + {33'd0, s1.added};
    mark_new = s1.set_cat ? {16'd0, s1.cval} : s1.nval;
    wr_cfg = s1_go && s1.setup && s1.idx_ok;
    wr_cnt = s1_go && (do_num || (do_cat && !miss_c));
    wr_num = s1_go && do_num;
    wr_bin = s1_go && do_bin;
    same_f = (op.feat == f);
  end

  // store reads; the update leaving stage 1 at this edge is forwarded
  always_ff @(posedge clk) begin
    if (take) begin
      s1      <= op;
      s1_sqp  <= {32'd0, mag} * {32'd0, mag};
      s1_hrd  <= (wr_bin && ha == raddr) ? hinc : hist[raddr];
      s1_type <= (wr_cfg && same_f) ? s1.set_cat : type_m[op.feat];
      s1_mark <= (wr_cfg && same_f) ? mark_new : mark_m[op.feat];
      s1_cnt  <= (wr_cnt && same_f) ? cnt_inc : cnt_m[op.feat];
      s1_min  <= (wr_num && same_f) ? min_n : min_m[op.feat];
      s1_max  <= (wr_num && same_f) ? max_n : max_m[op.feat];
      s1_sum  <= (wr_num && same_f) ? sum_n : sum_m[op.feat];
      s1_sq   <= (wr_num && same_f) ? sq_n : sq_m[op.feat];
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      hist[clr_addr[HW-1:0]] <= '0;
      type_m[clr_addr[5:0]]  <= 1'b0;
      mark_m[clr_addr[5:0]]  <= '0;
      cnt_m[clr_addr[5:0]]   <= '0;
      min_m[clr_addr[5:0]]   <= '0;
      max_m[clr_addr[5:0]]   <= '0;
      sum_m[clr_addr[5:0]]   <= '0;
      sq_m[clr_addr[5:0]]    <= '0;
    end else begin
      if (wr_bin) hist[ha] <= hinc;
      if (wr_cfg) begin
        type_m[f] <= s1.set_cat;
        mark_m[f] <= mark_new;
      end
      if (wr_cnt) cnt_m[f] <= cnt_inc;
      if (wr_num) begin
        min_m[f] <= min_n;
        max_m[f] <= max_n;
        sum_m[f] <= sum_n;
        sq_m[f]  <= sq_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      if (s1.add) total <= tot_w[48] ? MAX48 : tot_w[47:0];
      if ((s1.setup || s1.sample) && !s1.idx_ok) status <= ST_BAD_IDX;
      else if (do_cat && !s1.cat_ok)            status <= ST_CAT_OOR;
      else                                      status <= ST_OK;
      bin_count <= do_bin ? hinc : 32'd0;
      example_total <= s1.add ? (tot_w[48] ? MAX48 : tot_w[47:0]) : total;
      if (s1.idx_ok) begin
        present_count <= (do_num || (do_cat && !miss_c)) ? cnt_inc : s1_cnt;
        lowest_value  <= do_num ? min_n : s1_min;
        highest_value <= do_num ? max_n : s1_max;
        value_sum     <= do_num ? sum_n : s1_sum;
        square_sum    <= do_num ? sq_n : s1_sq;
      end else begin
        present_count <= '0;
        lowest_value  <= '0;
        highest_value <= '0;
        value_sum     <= '0;
        square_sum    <= '0;
      end
    end
    if (rst) begin
      s1_v      <= 1'b0;
      out_valid <= 1'b0;
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      total     <= '0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == (HW+1)'(HD - 1)) clr_busy <= 1'b0;
      end
      if (take) s1_v <= 1'b1;
      else if (s1_go) s1_v <= 1'b0;
      if (s1_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) clr_busy |-> !op_ready)
    else $error("accept during clear");
  assert property (@(posedge clk) disable iff (rst) out_hold |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst) out_hold |=> $stable(value_sum))
    else $error("result changed under stall");

endmodule

// File: design/feature_statistics_accumulator_top.sv
// Per-feature streaming statistics accumulator.
// Input channel (in_valid/in_ready) carries one item: set-up, sample or
// example-count add. Output channel (out_valid/out_ready) returns exactly
// one result per item, in order.
// Path: an accepted item passes the queue, then the store/histogram read with
// square multiply, then the update into the result register.
// Throughput: one item per cycle while the output is not stalled and no reset
// sweep runs; the per-feature and histogram read-modify-write forward the
// update of the item ahead, so back-to-back items on one feature or one bin are exact.
// Reset: the example total clears at once; the per-feature stores and the
// histogram RAM are then swept to zero, 64*2^ceil(log2(NUM_CATEGORIES))
// entries (16384 by default). The queue still takes two transactions during
// the sweep, after which in_ready stays low until the sweep ends.
// Stall: when out_ready is low the result holds, the update stage halts,
// and the two-entry queue keeps accepting until full.
module feature_statistics_accumulator_top import fsa_pkg::*; #(
  parameter int NUM_FEATURES   = 64,
  parameter int NUM_CATEGORIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [5:0]  feature_index,
  input  logic        set_categorical,
  input  logic [31:0] numeric_value,
  input  logic [15:0] category_value,
  input  logic [15:0] examples_added,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] present_count,
  output logic [31:0] lowest_value,
  output logic [31:0] highest_value,
  output logic [63:0] value_sum,
  output logic [62:0] square_sum,
  output logic [31:0] bin_count,
  output logic [47:0] example_total
);

  logic op_valid, op_ready;
  op_t  op;

  fsa_front #(.NUM_FEATURES(NUM_FEATURES), .NUM_CATEGORIES(NUM_CATEGORIES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .kind, .feature_index, .set_categorical,
    .numeric_value, .category_value, .examples_added,
    .op_valid, .op_ready, .op
  );

  fsa_back #(.NUM_CATEGORIES(NUM_CATEGORIES)) u_back (
    .clk, .rst, .op_valid, .op_ready, .op, .out_valid, .out_ready,
    .status, .present_count, .lowest_value, .highest_value, .value_sum,
    .square_sum, .bin_count, .example_total
  );

endmodule
